// ===== src/teq_pkg.sv =====
package teq_pkg;

    localparam int KEY_W = 18;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_POP    = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] client_id;
        logic [5:0] event_hours;
        logic [5:0] event_minutes;
        logic [5:0] event_seconds;
    } t_in_item;

    typedef struct packed {
        logic       ok;
        logic [7:0] due_client;
        logic [5:0] due_hours;
        logic [5:0] due_minutes;
        logic [5:0] due_seconds;
    } t_out_item;

    typedef struct packed {
        logic [7:0] client;
        logic [5:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_WAIT,
        S_INS_CMP,
        S_INS_PUT,
        S_FINISH
    } t_state;

endpackage

// ===== src/teq_in_if.sv =====
interface teq_in_if
    import teq_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/teq_out_if.sv =====
interface teq_out_if
    import teq_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/timed_event_queue.sv =====
// Rejected beats (insert when full, pop when empty) and an insert into an empty queue
// go from S_IDLE straight to S_FINISH; a pop first passes S_POP_WAIT for the head read.
// An insert that moves later entries reads and rewrites each of them in S_INS_CMP,
// through the single compare unit and the one-read, one-write queue memory.
// A new beat is accepted in the cycle after the result is registered.
// A synchronous reset empties the queue; the entry memory is not cleared.
module timed_event_queue
    import teq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    teq_in_if.sink      i_evt,
    teq_out_if.source   o_due
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_state           r_state, n_state;
    logic [AW-1:0]    r_head, n_head;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_j, n_j;
    t_entry           r_new, n_new;
    logic [KEY_W-1:0] r_key, n_key;
    t_out_item        r_res, n_res;
    logic             r_ovalid, n_ovalid;
    t_out_item        r_odata, n_odata;

    t_entry           mem [DEPTH];
    t_entry           r_rdata;
    logic [AW-1:0]    mem_raddr;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    t_entry           mem_wdata;

    t_entry           key_in;
    logic [KEY_W-1:0] key_out;
    logic             key_later;
    t_entry           in_ent;

    function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    teq_key u_key (
        .i_ent     (key_in),
        .i_ref_key (r_key),
        .o_key     (key_out),
        .o_later   (key_later)
    );

    assign in_ent.client  = i_evt.data.client_id;
    assign in_ent.hours   = i_evt.data.event_hours;
    assign in_ent.minutes = i_evt.data.event_minutes;
    assign in_ent.seconds = i_evt.data.event_seconds;

    assign i_evt.ready = (r_state == S_IDLE);
    assign o_due.valid = r_ovalid;
    assign o_due.data  = r_odata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_j      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_j      <= n_j;
            r_ovalid <= n_ovalid;
        end
        r_new   <= n_new;
        r_key   <= n_key;
        r_res   <= n_res;
        r_odata <= n_odata;
    end

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_j       = r_j;
        n_new     = r_new;
        n_key     = r_key;
        n_res     = r_res;
        n_ovalid  = r_ovalid;
        n_odata   = r_odata;
        mem_raddr = r_head;
        mem_we    = 1'b0;
        mem_waddr = wrap(r_head, r_j);
        mem_wdata = r_new;
        key_in    = r_rdata;

        if (r_ovalid && o_due.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                key_in = in_ent;
                if (i_evt.valid) begin
                    n_new = in_ent;
                    n_key = key_out;
                    n_res = '0;
                    if (i_evt.data.mode == MODE_POP) begin
                        if (r_count == '0) begin
                            n_state = S_FINISH;
                        end else begin
                            mem_raddr = r_head;
                            n_state   = S_POP_WAIT;
                        end
                    end else if (r_count == CW'(DEPTH)) begin
                        n_state = S_FINISH;
                    end else if (r_count == '0) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_head;
                        mem_wdata = in_ent;
                        n_count   = r_count + CW'(1);
                        n_res.ok  = 1'b1;
                        n_state   = S_FINISH;
                    end else begin
                        n_j       = r_count;
                        mem_raddr = wrap(r_head, r_count - CW'(1));
                        n_state   = S_INS_CMP;
                    end
                end
            end
            S_POP_WAIT: begin
                n_res.ok          = 1'b1;
                n_res.due_client  = r_rdata.client;
                n_res.due_hours   = r_rdata.hours;
                n_res.due_minutes = r_rdata.minutes;
                n_res.due_seconds = r_rdata.seconds;
                n_head            = wrap(r_head, CW'(1));
                n_count           = r_count - CW'(1);
                n_state           = S_FINISH;
            end
            S_INS_CMP: begin
                mem_we = 1'b1;
                if (key_later) begin
                    mem_wdata = r_rdata;
                    n_j       = r_j - CW'(1);
                    if (r_j == CW'(1)) begin
                        n_state = S_INS_PUT;
                    end else begin
                        mem_raddr = wrap(r_head, r_j - CW'(2));
                    end
                end else begin
                    mem_wdata = r_new;
                    n_count   = r_count + CW'(1);
                    n_res.ok  = 1'b1;
                    n_state   = S_FINISH;
                end
            end
            S_INS_PUT: begin
                mem_we    = 1'b1;
                mem_wdata = r_new;
                n_count   = r_count + CW'(1);
                n_res.ok  = 1'b1;
                n_state   = S_FINISH;
            end
            S_FINISH: begin
                if (!r_ovalid || o_due.ready) begin
                    n_odata  = r_res;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/teq_key.sv =====
module teq_key
    import teq_pkg::*;
(
    input  t_entry           i_ent,
    input  logic [KEY_W-1:0] i_ref_key,
    output logic [KEY_W-1:0] o_key,
    output logic             o_later
);

    assign o_key = KEY_W'(i_ent.hours) * KEY_W'(3600)
                 + KEY_W'(i_ent.minutes) * KEY_W'(60)
                 + KEY_W'(i_ent.seconds);

    assign o_later = (o_key > i_ref_key);

endmodule

// ===== tb/due_event_checker.sv =====
module due_event_checker
    import teq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    teq_in_if    i_evt,
    teq_out_if   i_due,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_inserted,
    output int   o_rejected,
    output int   o_popped,
    output int   o_empty_pops
);
    timeunit 1ns;
    timeprecision 1ps;

    t_entry    sched [DEPTH];
    int        sched_count;
    t_out_item due_expected [$];

    function automatic int unsigned event_key(input t_entry e);
        return int'(e.hours) * 3600 + int'(e.minutes) * 60 + int'(e.seconds);
    endfunction

    // Advances the schedule by one input beat and returns the result it must produce.
    function automatic t_out_item schedule_beat(input t_in_item item);
        t_out_item res;
        t_entry    fresh;
        int        pos;
        res = '0;
        if (item.mode == MODE_INSERT) begin
            if (sched_count < DEPTH) begin
                fresh.client  = item.client_id;
                fresh.hours   = item.event_hours;
                fresh.minutes = item.event_minutes;
                fresh.seconds = item.event_seconds;
                pos = sched_count;
                for (int i = 0; i < sched_count; i++) begin
                    if (pos == sched_count && event_key(sched[i]) > event_key(fresh)) begin
                        pos = i;
                    end
                end
                for (int i = sched_count; i > pos; i--) begin
                    sched[i] = sched[i - 1];
                end
                sched[pos] = fresh;
                sched_count++;
                res.ok = 1'b1;
            end
        end else if (sched_count > 0) begin
            res.ok          = 1'b1;
            res.due_client  = sched[0].client;
            res.due_hours   = sched[0].hours;
            res.due_minutes = sched[0].minutes;
            res.due_seconds = sched[0].seconds;
            for (int i = 1; i < sched_count; i++) begin
                sched[i - 1] = sched[i];
            end
            sched_count--;
        end
        return res;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_inserted   = 0;
        o_rejected   = 0;
        o_popped     = 0;
        o_empty_pops = 0;
        sched_count  = 0;
    end

    always @(posedge i_clk) begin
        t_out_item exp_res;
        t_out_item act_res;
        if (!i_rst_n) begin
            sched_count = 0;
            due_expected.delete();
        end else begin
            if (i_evt.valid && i_evt.ready) begin
                exp_res = schedule_beat(i_evt.data);
                due_expected.insert(due_expected.size(), exp_res);
                if (i_evt.data.mode == MODE_INSERT) begin
                    if (exp_res.ok) o_inserted++;
                    else o_rejected++;
                end else begin
                    if (exp_res.ok) o_popped++;
                    else o_empty_pops++;
                end
            end
            if (i_due.valid && i_due.ready) begin
                act_res = i_due.data;
                if (due_expected.size() == 0) begin
                    $display("%0t: unexpected due beat: ok=%0b client=%0d time=%0d:%0d:%0d",
                             $time, act_res.ok, act_res.due_client, act_res.due_hours,
                             act_res.due_minutes, act_res.due_seconds);
                    o_fail_count++;
                end else begin
                    exp_res = due_expected.pop_front();
                    if (act_res.ok !== exp_res.ok
                            || act_res.due_client !== exp_res.due_client
                            || act_res.due_hours !== exp_res.due_hours
                            || act_res.due_minutes !== exp_res.due_minutes
                            || act_res.due_seconds !== exp_res.due_seconds) begin
                        $display("%0t: due beat mismatch: expected ok=%0b client=%0d %0d:%0d:%0d",
                                 $time, exp_res.ok, exp_res.due_client, exp_res.due_hours,
                                 exp_res.due_minutes, exp_res.due_seconds);
                        $display("%0t:                      actual ok=%0b client=%0d %0d:%0d:%0d",
                                 $time, act_res.ok, act_res.due_client, act_res.due_hours,
                                 act_res.due_minutes, act_res.due_seconds);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = due_expected.size();
    end

endmodule

// ===== tb/timed_event_queue_tb.sv =====
module timed_event_queue_tb;
    import teq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int RAND_ITEMS  = 730;

    logic i_clk;
    logic i_rst_n;

    teq_in_if  evt_if ();
    teq_out_if due_if ();

    int fail_count;
    int pending;
    int n_inserted;
    int n_rejected;
    int n_popped;
    int n_empty_pops;

    bit calm;
    int hold_requests;
    int holds_served;
    int hold_left;
    int idle_cycles;

    timed_event_queue #(
        .DEPTH(DEPTH)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_evt  (evt_if),
        .o_due  (due_if)
    );

    due_event_checker #(
        .DEPTH(DEPTH)
    ) checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (evt_if),
        .i_due       (due_if),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_inserted  (n_inserted),
        .o_rejected  (n_rejected),
        .o_popped    (n_popped),
        .o_empty_pops(n_empty_pops)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_in_item make_insert(input logic [7:0] client, input logic [5:0] hours,
                                             input logic [5:0] minutes,
                                             input logic [5:0] seconds);
        t_in_item it;
        it.mode          = MODE_INSERT;
        it.client_id     = client;
        it.event_hours   = hours;
        it.event_minutes = minutes;
        it.event_seconds = seconds;
        return it;
    endfunction

    function automatic t_in_item make_pop();
        t_in_item it;
        it               = make_insert(8'($urandom_range(255)), 6'($urandom_range(63)),
                                       6'($urandom_range(63)), 6'($urandom_range(63)));
        it.mode          = MODE_POP;
        return it;
    endfunction

    function automatic t_in_item random_event(input int insert_pct);
        t_in_item it;
        it = make_pop();
        case ($urandom_range(3))
            0: begin
                // Keys that collide although the fields differ.
                case ($urandom_range(2))
                    0: begin
                        it.event_hours = 6'd1;  it.event_minutes = 6'd0;  it.event_seconds = 6'd0;
                    end
                    1: begin
                        it.event_hours = 6'd0;  it.event_minutes = 6'd60; it.event_seconds = 6'd0;
                    end
                    default: begin
                        it.event_hours = 6'd0;  it.event_minutes = 6'd59; it.event_seconds = 6'd60;
                    end
                endcase
            end
            1: begin
                it.event_hours   = 6'($urandom_range(1));
                it.event_minutes = 6'($urandom_range(1));
                it.event_seconds = 6'($urandom_range(3));
            end
            2: begin
            end
            default: begin
                it.event_hours   = 6'($urandom_range(59));
                it.event_minutes = 6'($urandom_range(59));
                it.event_seconds = 6'($urandom_range(59));
            end
        endcase
        it.mode = ($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_POP;
        return it;
    endfunction

    task automatic send_beat(input t_in_item item);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 13) gap = $urandom_range(1, 4);
        if (gap > 0) begin
            evt_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        evt_if.valid <= 1'b1;
        evt_if.data  <= item;
        @(posedge i_clk);
        while (!evt_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_pending();
        evt_if.valid <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
    endtask

    initial begin
        due_if.ready <= 1'b0;
        holds_served = 0;
        hold_left    = 0;
        forever begin
            @(negedge i_clk);
            if (holds_served < hold_requests) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                due_if.ready <= 1'b0;
                hold_left--;
            end else begin
                due_if.ready <= calm || ($urandom_range(99) >= 13);
            end
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((evt_if.valid && evt_if.ready) || (due_if.valid && due_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Timeout: no beat moved for %0d cycles.", STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial begin
        int sent;
        int phase;
        int phase_len;
        int insert_pct;
        calm          = 1'b0;
        hold_requests = 0;
        i_rst_n      <= 1'b0;
        evt_if.valid <= 1'b0;
        evt_if.data  <= '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_beat(make_pop());
        send_beat(make_insert(8'd255, 6'd59, 6'd59, 6'd59));
        send_beat(make_insert(8'd0, 6'd0, 6'd0, 6'd0));
        send_beat(make_insert(8'hAA, 6'd63, 6'd63, 6'd63));
        send_beat(make_insert(8'd1, 6'd1, 6'd0, 6'd0));
        send_beat(make_insert(8'd2, 6'd0, 6'd60, 6'd0));
        send_beat(make_insert(8'd3, 6'd0, 6'd59, 6'd60));
        send_beat(make_insert(8'h55, 6'd0, 6'd0, 6'd0));
        send_beat(make_insert(8'h80, 6'd30, 6'd30, 6'd30));
        send_beat(make_insert(8'h7F, 6'd0, 6'd0, 6'd63));
        send_beat(make_insert(8'h01, 6'd0, 6'd63, 6'd0));
        send_beat(make_insert(8'hFE, 6'd12, 6'd34, 6'd56));
        send_beat(make_insert(8'h10, 6'd59, 6'd59, 6'd58));
        send_beat(make_insert(8'h20, 6'd0, 6'd0, 6'd1));
        send_beat(make_insert(8'h40, 6'd1, 6'd0, 6'd0));
        send_beat(make_insert(8'h33, 6'd32, 6'd16, 6'd8));
        send_beat(make_insert(8'h0F, 6'd5, 6'd5, 6'd5));
        send_beat(make_insert(8'hC3, 6'd0, 6'd0, 6'd0));
        repeat (4) send_beat(make_pop());

        sent  = 0;
        phase = 0;
        while (sent < RAND_ITEMS) begin
            case ($urandom_range(2))
                0:       insert_pct = 80;
                1:       insert_pct = 20;
                default: insert_pct = 50;
            endcase
            calm = (phase == 2);
            if (phase == 1) begin
                insert_pct = 80;
                hold_requests++;
            end
            if (phase == 3) drain_pending();
            phase_len = $urandom_range(20, 60);
            repeat (phase_len) begin
                send_beat(random_event(insert_pct));
                sent++;
            end
            phase++;
        end
        calm = 1'b0;

        drain_pending();
        repeat (20) @(posedge i_clk);

        $display("Run covered %0d accepted inserts, %0d inserts into a full queue,",
                 n_inserted, n_rejected);
        $display("%0d pops of an event and %0d pops of an empty queue.", n_popped, n_empty_pops);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
